// ===== hw/rtl/frmsg_pkg.sv =====
// Shared types and constants for the firewall rule match / SYN guard block.
// No dependencies.
package frmsg_pkg;

    localparam logic [7:0] PROTO_TCP = 8'd6;

    localparam logic [2:0] RSN_KEPT      = 3'd0;
    localparam logic [2:0] RSN_SYN_LIMIT = 3'd1;
    localparam logic [2:0] RSN_BAD_FLAGS = 3'd2;
    localparam logic [2:0] RSN_NOT_WHITE = 3'd3;
    localparam logic [2:0] RSN_BLACK     = 3'd4;

    localparam logic OP_CHECK = 1'b0;
    localparam logic OP_RULE  = 1'b1;

    localparam logic [1:0] CFG_MODE    = 2'd0;
    localparam logic [1:0] CFG_ACTIVE  = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT = 2'd2;
    localparam logic [1:0] CFG_MAXSYN  = 2'd3;

    typedef struct packed {
        logic        op;
        logic [7:0]  protocol;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_port_num;
        logic [15:0] dst_port_num;
        logic [7:0]  syn_flag;
        logic [7:0]  ack_flag;
        logic [31:0] now_seconds;
        logic [3:0]  rule_slot;
    } item_t;

    typedef struct packed {
        logic       drop;
        logic [2:0] drop_reason;
        logic [4:0] matched_rule;
        logic       tracker_full;
    } result_t;

endpackage

// ===== hw/rtl/firewall_rule_match_syn_guard_unit.sv =====
// Top level of the five-tuple filter with SYN guard.
// Depends on frmsg_pkg, frmsg_front, frmsg_back.
//
// Use: s_ stream carries one packet header or rule write per word, s_tuser
// selects which; m_ stream returns one result word per input word, in order.
// Config writes via cfg_wr_en/cfg_index/cfg_wdata while idle.
// Path: the accepted word is registered in the front stage, then its result is
// registered in the output register, where it can be taken. The front holds one
// word at a time: s_tready is low after each accept while the front stage
// finishes the tracker's lookup-then-update pass.
// Tracker lookup compares all entries in parallel; rules likewise.
// Reset clears tracker valid bits and config registers (timeout 30, limit 5);
// rule entries are undefined until written.
// When m_tready is low, the output register holds its word, the back stage
// stops taking from the front, the front holds its one item, and s_tready
// stays low until the output word is taken.
module firewall_rule_match_syn_guard_unit #(
    parameter int RULE_ENTRIES  = 16,
    parameter int TRACK_ENTRIES = 64
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // protocol, src_addr, dst_addr, src_port_num, dst_port_num,
    // syn_flag, ack_flag, now_seconds, rule_slot; 4 pad bits
    input  logic [159:0] s_tdata,
    // op
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // drop, drop_reason, matched_rule, tracker_full; 6 pad bits
    output logic [15:0]  m_tdata,
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_wdata
);
    import frmsg_pkg::*;

    logic        mode_reg;
    logic [4:0]  active_reg;
    logic [15:0] tmo_reg;
    logic [7:0]  max_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b0; active_reg <= 5'd0;
            tmo_reg <= 16'd30; max_reg <= 8'd5;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_MODE:    mode_reg   <= cfg_wdata[0];
                CFG_ACTIVE:  active_reg <= cfg_wdata[4:0];
                CFG_TIMEOUT: tmo_reg    <= cfg_wdata;
                CFG_MAXSYN:  max_reg    <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    item_t in_item;
    assign in_item.op           = s_tuser;
    assign in_item.protocol     = s_tdata[7:0];
    assign in_item.src_addr     = s_tdata[39:8];
    assign in_item.dst_addr     = s_tdata[71:40];
    assign in_item.src_port_num = s_tdata[87:72];
    assign in_item.dst_port_num = s_tdata[103:88];
    assign in_item.syn_flag     = s_tdata[111:104];
    assign in_item.ack_flag     = s_tdata[119:112];
    assign in_item.now_seconds  = s_tdata[151:120];
    assign in_item.rule_slot    = s_tdata[155:152];

    logic q_valid, q_ready, q_done;
    item_t q_item;
    result_t q_res, o_res;

    frmsg_front #(.TRACK_ENTRIES(TRACK_ENTRIES)) u_front (
        .aclk, .aresetn, .in_valid(s_tvalid), .in_ready(s_tready), .in_item,
        .syn_timeout(tmo_reg), .max_syn(max_reg),
        .q_valid, .q_ready, .q_item, .q_done, .q_res);

    frmsg_back #(.RULE_ENTRIES(RULE_ENTRIES)) u_back (
        .aclk, .aresetn, .q_valid, .q_ready, .q_item, .q_done, .q_res,
        .filter_mode(mode_reg), .active_rules(active_reg),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_res(o_res));

    assign m_tdata = {6'd0, o_res.tracker_full, o_res.matched_rule,
                      o_res.drop_reason, o_res.drop};
endmodule

// ===== hw/rtl/frmsg_front.sv =====
// Front part: SYN tracker. Accepts items, resolves tracker state, forwards
// words to the rule stage. Depends on frmsg_pkg.
module frmsg_front #(
    parameter int TRACK_ENTRIES = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  frmsg_pkg::item_t     in_item,
    input  logic [15:0]          syn_timeout,
    input  logic [7:0]           max_syn,
    output logic                 q_valid,
    input  logic                 q_ready,
    output frmsg_pkg::item_t     q_item,
    output logic                 q_done,
    output frmsg_pkg::result_t   q_res
);
    import frmsg_pkg::*;

    localparam int TW = (TRACK_ENTRIES > 1) ? $clog2(TRACK_ENTRIES) : 1;

    logic [TRACK_ENTRIES-1:0] valid_reg;
    logic [31:0] src_reg [TRACK_ENTRIES];
    logic [7:0]  cnt_reg [TRACK_ENTRIES];
    logic [31:0] stamp_reg [TRACK_ENTRIES];

    logic     busy_reg;
    item_t    it_reg;
    logic     hit_reg, free_reg;
    logic [TW-1:0] hidx_reg, fidx_reg;
    logic [7:0]  sel_cnt_reg;
    logic [31:0] sel_stamp_reg;

    logic     hit_next, free_next;
    logic [TW-1:0] hidx_next, fidx_next;

    always_comb begin
        hit_next = 1'b0; free_next = 1'b0;
        hidx_next = '0; fidx_next = '0;
        for (int i = TRACK_ENTRIES - 1; i >= 0; i--) begin
            if (valid_reg[i] && src_reg[i] == in_item.src_addr) begin
                hit_next = 1'b1; hidx_next = TW'(i);
            end
            if (!valid_reg[i]) begin
                free_next = 1'b1; fidx_next = TW'(i);
            end
        end
    end

    logic tcp, bad;
    logic [TW-1:0] idx;
    logic [7:0] cnt, ncnt;
    logic [31:0] stamp;
    logic stale;
    assign tcp = it_reg.protocol == PROTO_TCP;
    assign bad = (it_reg.syn_flag > 8'd1) || (it_reg.ack_flag > 8'd1);
    assign idx = hit_reg ? hidx_reg : fidx_reg;
    assign cnt = hit_reg ? sel_cnt_reg : 8'd0;
    assign stamp = hit_reg ? sel_stamp_reg : it_reg.now_seconds;
    assign stale = (it_reg.now_seconds - stamp) > {16'd0, syn_timeout};

    logic track, blocked;
    assign track = tcp && !bad && (hit_reg || free_reg) && it_reg.op == OP_CHECK;
    assign blocked = track && cnt >= max_syn;

    always_comb begin
        logic [7:0] c;
        c = stale ? 8'd0 : cnt;
        if (it_reg.syn_flag[0] == 1'b0 && it_reg.ack_flag[0] && c == 8'd0)
            ncnt = 8'd0;
        else
            ncnt = c + it_reg.syn_flag - it_reg.ack_flag;
    end

    assign in_ready = !busy_reg;
    assign q_valid  = busy_reg;
    assign q_item   = it_reg;

    always_comb begin
        q_done = 1'b0;
        q_res  = '0;
        if (it_reg.op == OP_CHECK && tcp) begin
            if (bad) begin
                q_done = 1'b1; q_res.drop = 1'b1; q_res.drop_reason = RSN_BAD_FLAGS;
            end else if (blocked) begin
                q_done = 1'b1; q_res.drop = 1'b1; q_res.drop_reason = RSN_SYN_LIMIT;
            end else if (!hit_reg && !free_reg) begin
                q_res.tracker_full = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            valid_reg <= '0;
        end else begin
            if (in_valid && in_ready) begin
                busy_reg <= 1'b1;
                it_reg   <= in_item;
                hit_reg  <= hit_next; free_reg <= free_next;
                hidx_reg <= hidx_next; fidx_reg <= fidx_next;
                sel_cnt_reg   <= cnt_reg[hidx_next];
                sel_stamp_reg <= stamp_reg[hidx_next];
            end else if (busy_reg && q_ready) begin
                busy_reg <= 1'b0;
                if (track) begin
                    valid_reg[idx] <= 1'b1;
                    src_reg[idx]   <= it_reg.src_addr;
                    if (!blocked) begin
                        cnt_reg[idx] <= ncnt;
                        stamp_reg[idx] <= stale ? it_reg.now_seconds : stamp;
                    end else begin
                        cnt_reg[idx] <= cnt;
                        stamp_reg[idx] <= stamp;
                    end
                end
            end
        end
    end

    a_one_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && hit_reg |-> valid_reg[hidx_reg]) else $error("hit not valid");
    a_free: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && free_reg && !hit_reg |-> !valid_reg[fidx_reg]) else $error("free busy");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && !q_ready |=> busy_reg && $stable(it_reg)) else $error("front lost");
endmodule

// ===== hw/rtl/frmsg_back.sv =====
// Back part: rule table, first-match compare and output register.
// Depends on frmsg_pkg.
module frmsg_back #(
    parameter int RULE_ENTRIES = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  frmsg_pkg::item_t     q_item,
    input  logic                 q_done,
    input  frmsg_pkg::result_t   q_res,
    input  logic                 filter_mode,
    input  logic [4:0]           active_rules,
    output logic                 out_valid,
    input  logic                 out_ready,
    output frmsg_pkg::result_t   out_res
);
    import frmsg_pkg::*;

    logic [7:0]  rp [RULE_ENTRIES];
    logic [31:0] rs [RULE_ENTRIES];
    logic [31:0] rd [RULE_ENTRIES];
    logic [15:0] rsp [RULE_ENTRIES];
    logic [15:0] rdp [RULE_ENTRIES];

    logic     ov_reg;
    result_t  res_reg;
    logic [4:0] match;

    always_comb begin
        match = 5'd0;
        for (int i = RULE_ENTRIES - 1; i >= 0; i--) begin
            if (32'(i) < 32'(active_rules)
                && (rp[i] == 8'd0 || rp[i] == q_item.protocol)
                && (rs[i] == 32'd0 || rs[i] == q_item.src_addr)
                && (rd[i] == 32'd0 || rd[i] == q_item.dst_addr)
                && (rsp[i] == 16'd0 || rsp[i] == q_item.src_port_num)
                && (rdp[i] == 16'd0 || rdp[i] == q_item.dst_port_num))
                match = 5'(i + 1);
        end
    end

    result_t r;
    always_comb begin
        r = q_res;
        if (q_item.op == OP_RULE) begin
            r = '0;
        end else if (!q_done) begin
            r.matched_rule = match;
            if (!filter_mode && match == 5'd0) begin
                r.drop = 1'b1; r.drop_reason = RSN_NOT_WHITE;
            end else if (filter_mode && match != 5'd0) begin
                r.drop = 1'b1; r.drop_reason = RSN_BLACK;
            end
        end
    end

    assign q_ready   = !ov_reg || out_ready;
    assign out_valid = ov_reg;
    assign out_res   = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_reg <= 1'b0;
        end else begin
            if (q_ready) ov_reg <= q_valid;
            if (q_valid && q_ready) begin
                res_reg <= r;
                if (q_item.op == OP_RULE && 32'(q_item.rule_slot) < RULE_ENTRIES) begin
                    rp[q_item.rule_slot]  <= q_item.protocol;
                    rs[q_item.rule_slot]  <= q_item.src_addr;
                    rd[q_item.rule_slot]  <= q_item.dst_addr;
                    rsp[q_item.rule_slot] <= q_item.src_port_num;
                    rdp[q_item.rule_slot] <= q_item.dst_port_num;
                end
            end
        end
    end

    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        ov_reg && !out_ready |=> ov_reg && $stable(res_reg)) else $error("out lost");
    a_rsn: assert property (@(posedge aclk) disable iff (!aresetn)
        ov_reg |-> res_reg.drop == (res_reg.drop_reason != RSN_KEPT)) else $error("reason");
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        ov_reg && res_reg.tracker_full |-> res_reg.drop_reason != RSN_SYN_LIMIT)
        else $error("full");
endmodule
